@@ rtl/pac_pkg.sv @@
// ============================================================================
// pac_pkg - shared definitions for the proximity alarm controller
// Mode and transaction codes, register map and timing constants.
// ============================================================================
`default_nettype none

package pac_pkg;

  // Alarm modes as reported on the result channel
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_WATCH = 2'd1,
    MODE_ON    = 2'd2,
    MODE_TEST  = 2'd3
  } mode_e;

  // Input transaction kinds
  typedef enum logic [1:0] {
    KIND_UPDATE   = 2'd0,
    KIND_REQ_ON   = 2'd1,
    KIND_REQ_OFF  = 2'd2,
    KIND_START_TEST = 2'd3
  } kind_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_COLOUR_A    = 3'd0,
    REG_COLOUR_B    = 3'd1,
    REG_BLINK_MS    = 3'd2,
    REG_TRIGGER     = 3'd3,
    REG_TIMEOUT_MS  = 3'd4
  } reg_e;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ToneW   = 10;
  localparam int unsigned RgbW    = 24;

  localparam logic [ToneW-1:0] SirenMin      = 10'd400;
  localparam logic [ToneW-1:0] SirenMax      = 10'd1000;
  localparam logic [ToneW-1:0] SirenStep     = 10'd20;
  localparam logic [31:0]      SirenInterval = 32'd10;
  localparam logic [31:0]      TestDuration  = 32'd3000;
  localparam logic [ToneW-1:0] TestTone      = 10'd800;

  localparam logic [RgbW-1:0]  ColourAReset  = 24'hFF0000;
  localparam logic [RgbW-1:0]  ColourBReset  = 24'h0000FF;
  localparam logic [15:0]      BlinkReset    = 16'd250;
  localparam logic [15:0]      TriggerReset  = 16'd200;
  localparam logic [31:0]      TimeoutReset  = 32'd3000;

endpackage

`default_nettype wire

@@ rtl/proximity_alarm_controller_top.sv @@
// ============================================================================
// proximity_alarm_controller_top - proximity alarm with siren and blinker
// Off / watching / on / testing alarm driven by timestamped distance updates.
// ============================================================================
// One transaction per clock cycle is taken while out_stall_i does not hold
// the result register. The input is captured in an input register,
// and the whole mode update (elapsed-time compares, blink toggle, siren step,
// pending request handling) is one combinational pass that writes the state
// registers, which double as the result register. That state
// loop sets the rate. Every accepted transaction yields exactly one result:
// the mode after it and the currently latched RGB levels and buzzer tone.
// Configuration registers sit on an APB-style port at byte address 4*index
// and are meant to be written only while the block is idle.
`default_nettype none

module proximity_alarm_controller_top
  import pac_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,

  // Configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,

  // Input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       kind_i,
  input  wire logic [31:0]      now_ms_i,
  input  wire logic [15:0]      distance_i,

  // Result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [1:0]       mode_o,
  output logic      [7:0]       red_o,
  output logic      [7:0]       green_o,
  output logic      [7:0]       blue_o,
  output logic      [ToneW-1:0] tone_hz_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RgbW-1:0] colour_a_q, colour_b_q;
  logic [15:0]     blink_ms_q, trigger_q;
  logic [31:0]     timeout_q;
  logic            cfg_wr;
  reg_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write the addressed register; ignore writes beyond the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_a_q <= ColourAReset;
      colour_b_q <= ColourBReset;
      blink_ms_q <= BlinkReset;
      trigger_q  <= TriggerReset;
      timeout_q  <= TimeoutReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COLOUR_A:   colour_a_q <= pwdata[RgbW-1:0];
        REG_COLOUR_B:   colour_b_q <= pwdata[RgbW-1:0];
        REG_BLINK_MS:   blink_ms_q <= pwdata[15:0];
        REG_TRIGGER:    trigger_q  <= pwdata[15:0];
        REG_TIMEOUT_MS: timeout_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Return the addressed register on reads
  always_comb begin
    case (cfg_idx)
      REG_COLOUR_A:   prdata = {{(DataW-RgbW){1'b0}}, colour_a_q};
      REG_COLOUR_B:   prdata = {{(DataW-RgbW){1'b0}}, colour_b_q};
      REG_BLINK_MS:   prdata = {16'd0, blink_ms_q};
      REG_TRIGGER:    prdata = {16'd0, trigger_q};
      REG_TIMEOUT_MS: prdata = timeout_q;
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeding the state/result register
  // --------------------------------------------------------------------------
  logic        in_valid_q, out_valid_q;
  logic        out_ready, in_ready, fire_in, fire_c;
  kind_e       in_kind_q;
  logic [31:0] in_now_q;
  logic [15:0] in_dist_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;
  assign fire_in    = in_valid_i && in_ready;
  assign fire_c     = in_valid_q && out_ready;

  // Track occupancy of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      in_kind_q <= kind_e'(kind_i);
      in_now_q  <= now_ms_i;
      in_dist_q <= distance_i;
    end
  end

  // --------------------------------------------------------------------------
  // Alarm state (also the result register)
  // --------------------------------------------------------------------------
  mode_e            mode_q, mode_d;
  logic             pend_on_q, pend_on_d, pend_off_q, pend_off_d;
  logic [31:0]      detect_t_q, detect_t_d;
  logic [31:0]      blink_t_q, blink_t_d;
  logic [31:0]      test_t_q, test_t_d;
  logic [31:0]      siren_t_q, siren_t_d;
  logic             phase_q, phase_d;
  logic             rising_q, rising_d;
  logic [ToneW-1:0] freq_q, freq_d;
  logic [RgbW-1:0]  rgb_q, rgb_d;
  logic [ToneW-1:0] tone_q, tone_d;

  logic             near;
  logic [31:0]      el_detect, el_blink, el_siren, el_test;
  logic             blink_due, siren_due, watch_expired, test_done;
  logic [ToneW-1:0] freq_up, freq_dn;

  // Elapsed times, modulo 2^32
  assign near      = in_dist_q <= trigger_q;
  assign el_detect = near ? 32'd0 : (in_now_q - detect_t_q);
  assign el_blink  = in_now_q - blink_t_q;
  assign el_siren  = in_now_q - siren_t_q;
  assign el_test   = in_now_q - test_t_q;

  assign watch_expired = el_detect >= timeout_q;
  assign blink_due     = el_blink >= {16'd0, blink_ms_q};
  assign siren_due     = el_siren >= SirenInterval;
  assign test_done     = el_test >= TestDuration;
  assign freq_up       = freq_q + SirenStep;
  assign freq_dn       = freq_q - SirenStep;

  // On an update, run the mode handler, then apply latched requests; other kinds latch a request or start a test
  always_comb begin
    mode_d     = mode_q;
    pend_on_d  = pend_on_q;
    pend_off_d = pend_off_q;
    detect_t_d = detect_t_q;
    blink_t_d  = blink_t_q;
    test_t_d   = test_t_q;
    siren_t_d  = siren_t_q;
    phase_d    = phase_q;
    rising_d   = rising_q;
    freq_d     = freq_q;
    rgb_d      = rgb_q;
    tone_d     = tone_q;

    case (in_kind_q)
      KIND_UPDATE: begin
        case (mode_q)
          MODE_OFF: begin
            rgb_d  = '0;
            tone_d = '0;
            if (near) begin
              mode_d     = MODE_WATCH;
              detect_t_d = in_now_q;
            end
          end
          MODE_WATCH: begin
            if (near) begin
              detect_t_d = in_now_q;
            end
            if (watch_expired) begin
              mode_d = MODE_OFF;
              rgb_d  = '0;
              tone_d = '0;
            end else if (near) begin
              mode_d = MODE_ON;
            end
          end
          MODE_ON: begin
            if (blink_due) begin
              phase_d   = !phase_q;
              rgb_d     = !phase_q ? colour_a_q : colour_b_q;
              blink_t_d = in_now_q;
            end
            if (siren_due) begin
              tone_d    = freq_q;
              siren_t_d = in_now_q;
              if (rising_q) begin
                freq_d = freq_up;
                if (freq_up >= SirenMax) begin
                  rising_d = 1'b0;
                end
              end else begin
                freq_d = freq_dn;
                if (freq_dn <= SirenMin) begin
                  rising_d = 1'b1;
                end
              end
            end
            if (!near) begin
              mode_d     = MODE_WATCH;
              detect_t_d = in_now_q;
            end
          end
          default: begin
            if (test_done) begin
              mode_d = MODE_OFF;
              rgb_d  = '0;
              tone_d = '0;
            end else begin
              if (blink_due) begin
                phase_d   = !phase_q;
                rgb_d     = !phase_q ? colour_a_q : colour_b_q;
                blink_t_d = in_now_q;
              end
              tone_d = TestTone;
            end
          end
        endcase

        if (pend_on_q) begin
          mode_d    = MODE_ON;
          pend_on_d = 1'b0;
        end else if (pend_off_q) begin
          mode_d     = MODE_OFF;
          pend_off_d = 1'b0;
          rgb_d      = '0;
          tone_d     = '0;
        end
      end
      KIND_REQ_ON:  pend_on_d  = 1'b1;
      KIND_REQ_OFF: pend_off_d = 1'b1;
      default: begin
        mode_d   = MODE_TEST;
        test_t_d = in_now_q;
      end
    endcase
  end

  // Advance the state when a transaction leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      pend_on_q  <= 1'b0;
      pend_off_q <= 1'b0;
      detect_t_q <= '0;
      blink_t_q  <= '0;
      test_t_q   <= '0;
      siren_t_q  <= '0;
      phase_q    <= 1'b0;
      rising_q   <= 1'b1;
      freq_q     <= SirenMin;
      rgb_q      <= '0;
      tone_q     <= '0;
    end else if (fire_c) begin
      mode_q     <= mode_d;
      pend_on_q  <= pend_on_d;
      pend_off_q <= pend_off_d;
      detect_t_q <= detect_t_d;
      blink_t_q  <= blink_t_d;
      test_t_q   <= test_t_d;
      siren_t_q  <= siren_t_d;
      phase_q    <= phase_d;
      rising_q   <= rising_d;
      freq_q     <= freq_d;
      rgb_q      <= rgb_d;
      tone_q     <= tone_d;
    end
  end

  // Drive the result channel straight from the state
  assign out_valid_o = out_valid_q;
  assign mode_o      = mode_q;
  assign red_o       = rgb_q[23:16];
  assign green_o     = rgb_q[15:8];
  assign blue_o      = rgb_q[7:0];
  assign tone_hz_o   = tone_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_siren_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freq_q >= SirenMin && freq_q <= SirenMax)
    else $error("siren frequency left its sweep range");

  a_tone_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_q == '0 || (tone_q >= SirenMin && tone_q <= SirenMax))
    else $error("latched tone outside silent or siren range");

  a_pend_on_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_on_q) |-> $past(fire_c && in_kind_q == KIND_REQ_ON))
    else $error("turn-on request latched without a request transaction");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled while the input register is empty");

endmodule

`default_nettype wire
